// ----- src/lobm_pkg.sv -----
`timescale 1ns / 1ps

package lobm_pkg;

    // fixed field widths of the request and result channels
    localparam int ID_W     = 12;
    localparam int PX_W     = 10;
    localparam int QIN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 16;
    localparam int REMOV_W  = 13;

    // operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    // side codes
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED     = 3'd0,
        STAT_CANCELLED = 3'd1,
        STAT_UNKNOWN   = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_ZERO_QTY  = 3'd4
    } status_t;

endpackage

// ----- src/lobm_ram.sv -----
`timescale 1ns / 1ps

module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/limit_order_book_matcher_core.sv -----
`timescale 1ns / 1ps
// channel   ports                                   direction  handshake
// request   s_operation s_order_id s_side           in         s_valid / s_ready
//           s_price_tick s_quantity
// result    m_status m_filled_quantity              out        m_valid / m_ready
//           m_orders_removed m_bid_present m_best_bid_price
//           m_ask_present m_best_ask_price
//
// a rejected request ends after its slot read; an add also reads its level and
// links in at the tail; each trade step reads both level heads and both orders,
// plus a removal per removed order; an emptied level is searched level by level
// this order of steps is set by the single read port of the order and level memories
// after reset a clearing pass over both memories runs before the first request
// is taken
// a finished result waits in the output register; the next request is taken
// meanwhile and only its final step stalls on m_ready

module limit_order_book_matcher_core #(
    parameter int ORDER_SLOTS  = 4096,
    parameter int PRICE_LEVELS = 1024,
    parameter int QTY_BITS     = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [lobm_pkg::ID_W-1:0]      s_order_id,
    input  logic                           s_side,
    input  logic [lobm_pkg::PX_W-1:0]      s_price_tick,
    input  logic [lobm_pkg::QIN_W-1:0]     s_quantity,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lobm_pkg::STATUS_W-1:0]  m_status,
    output logic [lobm_pkg::FILL_W-1:0]    m_filled_quantity,
    output logic [lobm_pkg::REMOV_W-1:0]   m_orders_removed,
    output logic                           m_bid_present,
    output logic [lobm_pkg::PX_W-1:0]      m_best_bid_price,
    output logic                           m_ask_present,
    output logic [lobm_pkg::PX_W-1:0]      m_best_ask_price
);

    import lobm_pkg::*;

    localparam int IDX_BITS  = $clog2(ORDER_SLOTS);
    localparam int LINK_BITS = $clog2(ORDER_SLOTS + 1);
    localparam int LV_BITS   = $clog2(PRICE_LEVELS);
    localparam int BEST_BITS = LV_BITS + 1;
    localparam int LVL_DEPTH = 2 * (2 ** LV_BITS);
    localparam int CLR_DEPTH = (ORDER_SLOTS > LVL_DEPTH) ? ORDER_SLOTS : LVL_DEPTH;
    localparam int CLR_BITS  = $clog2(CLR_DEPTH);

    localparam logic [LINK_BITS-1:0] NO_LINK    = LINK_BITS'(ORDER_SLOTS);
    localparam logic [BEST_BITS-1:0] EMPTY_MARK = BEST_BITS'(PRICE_LEVELS);
    localparam logic [LV_BITS-1:0]   PX_TOP     = LV_BITS'(PRICE_LEVELS - 1);
    localparam logic [31:0]          QTY_MAX    = 32'hFFFF_FFFF >> (32 - QTY_BITS);
    localparam logic [CLR_BITS-1:0]  CLR_LAST   = CLR_BITS'(CLR_DEPTH - 1);

    typedef struct packed {
        logic                 valid;
        logic                 side;
        logic [LV_BITS-1:0]   price;
        logic [QTY_BITS-1:0]  rem;
        logic [LINK_BITS-1:0] prev;
        logic [LINK_BITS-1:0] next;
    } slot_t;

    typedef struct packed {
        logic                 occ;
        logic [LINK_BITS-1:0] head;
        logic [LINK_BITS-1:0] tail;
    } level_t;

    typedef enum logic [20:0] {
        ST_CLR  = 21'h000001,
        ST_IDLE = 21'h000002,
        ST_SRD  = 21'h000004,
        ST_LRD  = 21'h000008,
        ST_JWR  = 21'h000010,
        ST_MCHK = 21'h000020,
        ST_MLB  = 21'h000040,
        ST_MLA  = 21'h000080,
        ST_MSB  = 21'h000100,
        ST_MSA  = 21'h000200,
        ST_MWA  = 21'h000400,
        ST_MDA  = 21'h000800,
        ST_D0   = 21'h001000,
        ST_D1   = 21'h002000,
        ST_DPV  = 21'h004000,
        ST_DNX  = 21'h008000,
        ST_DEND = 21'h010000,
        ST_SCRD = 21'h020000,
        ST_SCCK = 21'h040000,
        ST_DONE = 21'h080000,
        ST_SPARE_UNUSED_GUARD = 21'h100000
    } state_t;

    typedef enum logic [2:0] {
        RET_CANCEL = 3'b001,
        RET_B      = 3'b010,
        RET_A      = 3'b100
    } ret_t;

    // memory ports
    logic                  slot_we, slot_re;
    logic [IDX_BITS-1:0]   slot_waddr, slot_raddr;
    slot_t                 slot_wdata, slot_rdata;
    logic                  lvl_we, lvl_re;
    logic [LV_BITS:0]      lvl_waddr, lvl_raddr;
    level_t                lvl_wdata, lvl_rdata;

    // control state
    state_t                state_reg, state_next;
    logic [CLR_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [BEST_BITS-1:0]  best_bid_reg, best_bid_next;
    logic [BEST_BITS-1:0]  best_ask_reg, best_ask_next;
    logic                  m_valid_reg, m_valid_next;

    // working registers of the current request
    logic                  op_reg, op_next;
    logic                  inrange_reg, inrange_next;
    logic                  qzero_reg, qzero_next;
    logic [IDX_BITS-1:0]   id_reg, id_next;
    logic                  sd_reg, sd_next;
    logic [LV_BITS-1:0]    px_reg, px_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    status_t               status_reg, status_next;
    logic [FILL_W-1:0]     filled_reg, filled_next;
    logic [REMOV_W-1:0]    removed_reg, removed_next;
    logic [LINK_BITS-1:0]  tail_reg, tail_next;
    logic [LINK_BITS-1:0]  b_link_reg, b_link_next;
    slot_t                 b_data_reg, b_data_next;
    slot_t                 a_data_reg, a_data_next;
    logic [IDX_BITS-1:0]   a_id_reg, a_id_next;

    // order removal working set
    logic [IDX_BITS-1:0]   dr_id_reg, dr_id_next;
    logic                  dr_side_reg, dr_side_next;
    logic [LV_BITS-1:0]    dr_px_reg, dr_px_next;
    logic [LINK_BITS-1:0]  dr_prev_reg, dr_prev_next;
    logic [LINK_BITS-1:0]  dr_next_reg, dr_next_next;
    logic                  dr_empty_reg, dr_empty_next;
    ret_t                  dr_ret_reg, dr_ret_next;
    logic [LV_BITS-1:0]    scan_p_reg, scan_p_next;

    // output payload
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [FILL_W-1:0]     m_filled_reg, m_filled_next;
    logic [REMOV_W-1:0]    m_removed_reg, m_removed_next;
    logic                  m_bidp_reg, m_bidp_next;
    logic [PX_W-1:0]       m_bidpx_reg, m_bidpx_next;
    logic                  m_askp_reg, m_askp_next;
    logic [PX_W-1:0]       m_askpx_reg, m_askpx_next;

    lobm_ram #(.WIDTH($bits(slot_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_en   (slot_re),
        .rd_addr (slot_raddr),
        .rd_data (slot_rdata)
    );

    lobm_ram #(.WIDTH($bits(level_t)), .DEPTH(LVL_DEPTH)) u_level_ram (
        .aclk    (aclk),
        .wr_en   (lvl_we),
        .wr_addr (lvl_waddr),
        .wr_data (lvl_wdata),
        .rd_en   (lvl_re),
        .rd_addr (lvl_raddr),
        .rd_data (lvl_rdata)
    );

    // return point after an order removal
    state_t ret_state;
    always_comb begin
        case (dr_ret_reg)
            RET_CANCEL: ret_state = ST_DONE;
            RET_B:      ret_state = ST_MDA;
            RET_A:      ret_state = ST_MCHK;
            default:    ret_state = ST_DONE;
        endcase
    end

    // request field conditioning
    logic [31:0] id_ext, px_ext, q_ext, bid_ext, ask_ext;
    logic [31:0] trade_ext;
    logic [QTY_BITS-1:0] trade;
    assign id_ext  = 32'(s_order_id);
    assign px_ext  = 32'(s_price_tick);
    assign q_ext   = 32'(s_quantity);
    assign bid_ext = 32'(best_bid_reg);
    assign ask_ext = 32'(best_ask_reg);
    assign trade   = (b_data_reg.rem < slot_rdata.rem) ? b_data_reg.rem : slot_rdata.rem;
    assign trade_ext = 32'(trade);

    assign s_ready = (state_reg == ST_IDLE);

    // main sequencer
    always_comb begin
        logic [LINK_BITS-1:0] new_head, new_tail;
        logic                 lvl_empty;

        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        best_bid_next = best_bid_reg;
        best_ask_next = best_ask_reg;
        op_next       = op_reg;
        inrange_next  = inrange_reg;
        qzero_next    = qzero_reg;
        id_next       = id_reg;
        sd_next       = sd_reg;
        px_next       = px_reg;
        qty_next      = qty_reg;
        status_next   = status_reg;
        filled_next   = filled_reg;
        removed_next  = removed_reg;
        tail_next     = tail_reg;
        b_link_next   = b_link_reg;
        b_data_next   = b_data_reg;
        a_data_next   = a_data_reg;
        a_id_next     = a_id_reg;
        dr_id_next    = dr_id_reg;
        dr_side_next  = dr_side_reg;
        dr_px_next    = dr_px_reg;
        dr_prev_next  = dr_prev_reg;
        dr_next_next  = dr_next_reg;
        dr_empty_next = dr_empty_reg;
        dr_ret_next   = dr_ret_reg;
        scan_p_next   = scan_p_reg;

        slot_we    = 1'b0;
        slot_waddr = id_reg;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = id_reg;
        lvl_we     = 1'b0;
        lvl_waddr  = {sd_reg, px_reg};
        lvl_wdata  = '0;
        lvl_re     = 1'b0;
        lvl_raddr  = {sd_reg, px_reg};
        new_head   = '0;
        new_tail   = '0;
        lvl_empty  = 1'b0;

        case (state_reg)
            // zero both memories after reset
            ST_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_cnt_reg[IDX_BITS-1:0];
                lvl_we     = 1'b1;
                lvl_waddr  = clr_cnt_reg[LV_BITS:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            // take a request and fetch its slot
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    inrange_next = (id_ext < 32'(ORDER_SLOTS));
                    qzero_next   = (s_quantity == '0);
                    id_next      = id_ext[IDX_BITS-1:0];
                    sd_next      = s_side;
                    px_next      = (px_ext >= 32'(PRICE_LEVELS)) ? PX_TOP
                                                                 : px_ext[LV_BITS-1:0];
                    qty_next     = (q_ext > QTY_MAX) ? QTY_MAX[QTY_BITS-1:0]
                                                     : q_ext[QTY_BITS-1:0];
                    filled_next  = '0;
                    removed_next = '0;
                    slot_re      = 1'b1;
                    slot_raddr   = id_ext[IDX_BITS-1:0];
                    state_next   = ST_SRD;
                end
            end

            // classify the request
            ST_SRD: begin
                if (op_reg == OP_CANCEL) begin
                    if (!inrange_reg || !slot_rdata.valid) begin
                        status_next = STAT_UNKNOWN;
                        state_next  = ST_DONE;
                    end else begin
                        status_next  = STAT_CANCELLED;
                        dr_id_next   = id_reg;
                        dr_side_next = slot_rdata.side;
                        dr_px_next   = slot_rdata.price;
                        dr_prev_next = slot_rdata.prev;
                        dr_next_next = slot_rdata.next;
                        dr_ret_next  = RET_CANCEL;
                        state_next   = ST_D0;
                    end
                end else if (!inrange_reg) begin
                    status_next = STAT_UNKNOWN;
                    state_next  = ST_DONE;
                end else if (slot_rdata.valid) begin
                    status_next = STAT_DUPLICATE;
                    state_next  = ST_DONE;
                end else if (qzero_reg) begin
                    status_next = STAT_ZERO_QTY;
                    state_next  = ST_DONE;
                end else begin
                    status_next = STAT_ADDED;
                    lvl_re      = 1'b1;
                    state_next  = ST_LRD;
                end
            end

            // append the new order at the level tail
            ST_LRD: begin
                slot_we          = 1'b1;
                slot_wdata.valid = 1'b1;
                slot_wdata.side  = sd_reg;
                slot_wdata.price = px_reg;
                slot_wdata.rem   = qty_reg;
                slot_wdata.next  = NO_LINK;
                slot_wdata.prev  = lvl_rdata.occ ? lvl_rdata.tail : NO_LINK;
                lvl_we           = 1'b1;
                lvl_wdata.occ    = 1'b1;
                lvl_wdata.head   = lvl_rdata.occ ? lvl_rdata.head : LINK_BITS'(id_reg);
                lvl_wdata.tail   = LINK_BITS'(id_reg);
                tail_next        = lvl_rdata.tail;
                if (sd_reg == SIDE_ASK) begin
                    if (best_ask_reg == EMPTY_MARK || BEST_BITS'(px_reg) < best_ask_reg) begin
                        best_ask_next = BEST_BITS'(px_reg);
                    end
                end else begin
                    if (best_bid_reg == EMPTY_MARK || BEST_BITS'(px_reg) > best_bid_reg) begin
                        best_bid_next = BEST_BITS'(px_reg);
                    end
                end
                if (lvl_rdata.occ && lvl_rdata.tail < NO_LINK) begin
                    slot_re    = 1'b1;
                    slot_raddr = lvl_rdata.tail[IDX_BITS-1:0];
                    state_next = ST_JWR;
                end else begin
                    state_next = ST_MCHK;
                end
            end

            // link the old tail forward to the new order
            ST_JWR: begin
                slot_we         = 1'b1;
                slot_waddr      = tail_reg[IDX_BITS-1:0];
                slot_wdata      = slot_rdata;
                slot_wdata.next = LINK_BITS'(id_reg);
                state_next      = ST_MCHK;
            end

            // book crossed: fetch best bid level
            ST_MCHK: begin
                if (best_bid_reg != EMPTY_MARK && best_ask_reg != EMPTY_MARK &&
                    best_bid_reg >= best_ask_reg) begin
                    lvl_re     = 1'b1;
                    lvl_raddr  = {SIDE_BID, best_bid_reg[LV_BITS-1:0]};
                    state_next = ST_MLB;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_MLB: begin
                b_link_next = lvl_rdata.head;
                lvl_re      = 1'b1;
                lvl_raddr   = {SIDE_ASK, best_ask_reg[LV_BITS-1:0]};
                state_next  = ST_MLA;
            end

            ST_MLA: begin
                if (b_link_reg >= NO_LINK || lvl_rdata.head >= NO_LINK) begin
                    state_next = ST_DONE;
                end else begin
                    a_id_next  = lvl_rdata.head[IDX_BITS-1:0];
                    slot_re    = 1'b1;
                    slot_raddr = b_link_reg[IDX_BITS-1:0];
                    state_next = ST_MSB;
                end
            end

            ST_MSB: begin
                b_data_next = slot_rdata;
                slot_re     = 1'b1;
                slot_raddr  = a_id_reg;
                state_next  = ST_MSA;
            end

            // trade the smaller remaining quantity
            ST_MSA: begin
                filled_next     = filled_reg + trade_ext[FILL_W-1:0];
                b_data_next.rem = b_data_reg.rem - trade;
                a_data_next     = slot_rdata;
                a_data_next.rem = slot_rdata.rem - trade;
                slot_we         = 1'b1;
                slot_waddr      = b_link_reg[IDX_BITS-1:0];
                slot_wdata      = b_data_reg;
                slot_wdata.rem  = b_data_reg.rem - trade;
                state_next      = ST_MWA;
            end

            ST_MWA: begin
                slot_we    = 1'b1;
                slot_waddr = a_id_reg;
                slot_wdata = a_data_reg;
                if (b_data_reg.rem == '0) begin
                    removed_next = removed_reg + 1'b1;
                    dr_id_next   = b_link_reg[IDX_BITS-1:0];
                    dr_side_next = b_data_reg.side;
                    dr_px_next   = b_data_reg.price;
                    dr_prev_next = b_data_reg.prev;
                    dr_next_next = b_data_reg.next;
                    dr_ret_next  = RET_B;
                    state_next   = ST_D0;
                end else begin
                    state_next = ST_MDA;
                end
            end

            ST_MDA: begin
                if (a_data_reg.rem == '0) begin
                    removed_next = removed_reg + 1'b1;
                    dr_id_next   = a_id_reg;
                    dr_side_next = a_data_reg.side;
                    dr_px_next   = a_data_reg.price;
                    dr_prev_next = a_data_reg.prev;
                    dr_next_next = a_data_reg.next;
                    dr_ret_next  = RET_A;
                    state_next   = ST_D0;
                end else begin
                    state_next = ST_MCHK;
                end
            end

            // removal: free the slot, fetch its level
            ST_D0: begin
                slot_we          = 1'b1;
                slot_waddr       = dr_id_reg;
                slot_wdata.valid = 1'b0;
                slot_wdata.side  = dr_side_reg;
                slot_wdata.price = dr_px_reg;
                slot_wdata.prev  = dr_prev_reg;
                slot_wdata.next  = dr_next_reg;
                lvl_re           = 1'b1;
                lvl_raddr        = {dr_side_reg, dr_px_reg};
                state_next       = ST_D1;
            end

            // unlink from level head and tail
            ST_D1: begin
                new_head  = (dr_prev_reg < NO_LINK) ? lvl_rdata.head : dr_next_reg;
                new_tail  = (dr_next_reg < NO_LINK) ? lvl_rdata.tail : dr_prev_reg;
                lvl_empty = (new_head >= NO_LINK);
                lvl_we         = 1'b1;
                lvl_waddr      = {dr_side_reg, dr_px_reg};
                lvl_wdata.occ  = !lvl_empty;
                lvl_wdata.head = new_head;
                lvl_wdata.tail = new_tail;
                dr_empty_next  = lvl_empty;
                if (dr_prev_reg < NO_LINK) begin
                    slot_re    = 1'b1;
                    slot_raddr = dr_prev_reg[IDX_BITS-1:0];
                    state_next = ST_DPV;
                end else if (dr_next_reg < NO_LINK) begin
                    slot_re    = 1'b1;
                    slot_raddr = dr_next_reg[IDX_BITS-1:0];
                    state_next = ST_DNX;
                end else begin
                    state_next = ST_DEND;
                end
            end

            ST_DPV: begin
                slot_we         = 1'b1;
                slot_waddr      = dr_prev_reg[IDX_BITS-1:0];
                slot_wdata      = slot_rdata;
                slot_wdata.next = dr_next_reg;
                if (dr_next_reg < NO_LINK) begin
                    slot_re    = 1'b1;
                    slot_raddr = dr_next_reg[IDX_BITS-1:0];
                    state_next = ST_DNX;
                end else begin
                    state_next = ST_DEND;
                end
            end

            ST_DNX: begin
                slot_we         = 1'b1;
                slot_waddr      = dr_next_reg[IDX_BITS-1:0];
                slot_wdata      = slot_rdata;
                slot_wdata.prev = dr_prev_reg;
                state_next      = ST_DEND;
            end

            // an emptied level starts a search from the old best
            ST_DEND: begin
                if (dr_empty_reg) begin
                    scan_p_next = (dr_side_reg == SIDE_ASK) ? best_ask_reg[LV_BITS-1:0]
                                                            : best_bid_reg[LV_BITS-1:0];
                    state_next  = ST_SCRD;
                end else begin
                    state_next = ret_state;
                end
            end

            ST_SCRD: begin
                lvl_re     = 1'b1;
                lvl_raddr  = {dr_side_reg, scan_p_reg};
                state_next = ST_SCCK;
            end

            ST_SCCK: begin
                if (lvl_rdata.occ) begin
                    if (dr_side_reg == SIDE_ASK) begin
                        best_ask_next = BEST_BITS'(scan_p_reg);
                    end else begin
                        best_bid_next = BEST_BITS'(scan_p_reg);
                    end
                    state_next = ret_state;
                end else if (dr_side_reg == SIDE_ASK && scan_p_reg == PX_TOP) begin
                    best_ask_next = EMPTY_MARK;
                    state_next    = ret_state;
                end else if (dr_side_reg == SIDE_BID && scan_p_reg == '0) begin
                    best_bid_next = EMPTY_MARK;
                    state_next    = ret_state;
                end else begin
                    scan_p_next = (dr_side_reg == SIDE_ASK) ? scan_p_reg + 1'b1
                                                            : scan_p_reg - 1'b1;
                    state_next  = ST_SCRD;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    logic load_out;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next   = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_status_next  = m_status_reg;
        m_filled_next  = m_filled_reg;
        m_removed_next = m_removed_reg;
        m_bidp_next    = m_bidp_reg;
        m_bidpx_next   = m_bidpx_reg;
        m_askp_next    = m_askp_reg;
        m_askpx_next   = m_askpx_reg;
        if (load_out) begin
            m_status_next  = status_reg;
            m_filled_next  = filled_reg;
            m_removed_next = removed_reg;
            m_bidp_next    = (best_bid_reg != EMPTY_MARK);
            m_bidpx_next   = (best_bid_reg != EMPTY_MARK) ? bid_ext[PX_W-1:0] : '0;
            m_askp_next    = (best_ask_reg != EMPTY_MARK);
            m_askpx_next   = (best_ask_reg != EMPTY_MARK) ? ask_ext[PX_W-1:0] : '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            best_bid_reg <= EMPTY_MARK;
            best_ask_reg <= EMPTY_MARK;
            m_valid_reg  <= 1'b0;
            dr_ret_reg   <= RET_CANCEL;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            best_bid_reg <= best_bid_next;
            best_ask_reg <= best_ask_next;
            m_valid_reg  <= m_valid_next;
            dr_ret_reg   <= dr_ret_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        inrange_reg   <= inrange_next;
        qzero_reg     <= qzero_next;
        id_reg        <= id_next;
        sd_reg        <= sd_next;
        px_reg        <= px_next;
        qty_reg       <= qty_next;
        status_reg    <= status_next;
        filled_reg    <= filled_next;
        removed_reg   <= removed_next;
        tail_reg      <= tail_next;
        b_link_reg    <= b_link_next;
        b_data_reg    <= b_data_next;
        a_data_reg    <= a_data_next;
        a_id_reg      <= a_id_next;
        dr_id_reg     <= dr_id_next;
        dr_side_reg   <= dr_side_next;
        dr_px_reg     <= dr_px_next;
        dr_prev_reg   <= dr_prev_next;
        dr_next_reg   <= dr_next_next;
        dr_empty_reg  <= dr_empty_next;
        scan_p_reg    <= scan_p_next;
        m_status_reg  <= m_status_next;
        m_filled_reg  <= m_filled_next;
        m_removed_reg <= m_removed_next;
        m_bidp_reg    <= m_bidp_next;
        m_bidpx_reg   <= m_bidpx_next;
        m_askp_reg    <= m_askp_next;
        m_askpx_reg   <= m_askpx_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_filled_quantity = m_filled_reg;
    assign m_orders_removed  = m_removed_reg;
    assign m_bid_present     = m_bidp_reg;
    assign m_best_bid_price  = m_bidpx_reg;
    assign m_ask_present     = m_askp_reg;
    assign m_best_ask_price  = m_askpx_reg;

    // no request is taken while the memories are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_ready)
        else $error("request taken during clearing pass");

    // never read an entry in the cycle it is written
    a_slot_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_we && slot_re) |-> (slot_waddr != slot_raddr))
        else $error("order memory read and write collide");

    a_level_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (lvl_we && lvl_re) |-> (lvl_waddr != lvl_raddr))
        else $error("level memory read and write collide");

    // a result only appears from the completion step
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    // best prices stay within the level range or the empty marker
    a_best_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_bid_reg <= EMPTY_MARK) && (best_ask_reg <= EMPTY_MARK))
        else $error("best price out of range");

endmodule

// ----- tb/sv/limit_order_book_matcher_core_tb.sv -----
`timescale 1ns / 1ps

module limit_order_book_matcher_core_tb;
    import lobm_pkg::*;

    localparam int SLOTS    = 4096;
    localparam int LEVELS   = 1024;
    localparam int NO_LINK  = SLOTS;
    localparam int NO_PRICE = LEVELS;
    localparam int WATCHDOG = 200000;

    typedef struct {
        status_t     status;
        logic [15:0] filled;
        logic [12:0] removed;
        logic        bid_on;
        logic [9:0]  bid_px;
        logic        ask_on;
        logic [9:0]  ask_px;
    } book_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [11:0] s_order_id;
    logic        s_side;
    logic [9:0]  s_price_tick;
    logic [15:0] s_quantity;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [15:0] m_filled_quantity;
    logic [12:0] m_orders_removed;
    logic        m_bid_present;
    logic [9:0]  m_best_bid_price;
    logic        m_ask_present;
    logic [9:0]  m_best_ask_price;

    // book shadow
    bit          ord_live [SLOTS];
    bit          ord_side [SLOTS];
    int unsigned ord_px   [SLOTS];
    int unsigned ord_left [SLOTS];
    int unsigned ord_prev [SLOTS];
    int unsigned ord_next [SLOTS];
    int unsigned lvl_head [2*LEVELS];
    int unsigned lvl_tail [2*LEVELS];
    bit          lvl_busy [2*LEVELS];
    int unsigned top_bid;
    int unsigned top_ask;

    book_result_t pending_fills[$];
    int  errors;
    int  idle_cycles;
    bit  quiet_phase;
    int  mid_px;

    limit_order_book_matcher_core dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void rescan_bid();
        top_bid = NO_PRICE;
        for (int p = LEVELS - 1; p >= 0; p--) begin
            if (lvl_busy[p]) begin
                top_bid = p;
                return;
            end
        end
    endfunction

    function automatic void rescan_ask();
        top_ask = NO_PRICE;
        for (int p = 0; p < LEVELS; p++) begin
            if (lvl_busy[LEVELS + p]) begin
                top_ask = p;
                return;
            end
        end
    endfunction

    function automatic void unlink_order(int unsigned id);
        int unsigned lv;
        int unsigned pv;
        int unsigned nx;
        lv = (ord_side[id] ? LEVELS : 0) + ord_px[id];
        pv = ord_prev[id];
        nx = ord_next[id];
        if (pv < NO_LINK) ord_next[pv] = nx; else lvl_head[lv] = nx;
        if (nx < NO_LINK) ord_prev[nx] = pv; else lvl_tail[lv] = pv;
        ord_live[id] = 0;
        if (lvl_head[lv] >= NO_LINK) begin
            lvl_busy[lv] = 0;
            if (ord_side[id]) rescan_ask(); else rescan_bid();
        end
    endfunction

    // apply one request to the shadow book and return its expected result
    function automatic book_result_t apply_request(logic op, logic [11:0] id, logic sd,
                                                   logic [9:0] px, logic [15:0] qty);
        book_result_t r;
        int unsigned lv;
        int unsigned b;
        int unsigned a;
        int unsigned t;
        int unsigned filled;
        int unsigned removed;
        filled  = 0;
        removed = 0;
        if (op == OP_CANCEL) begin
            if (!ord_live[id]) begin
                r.status = STAT_UNKNOWN;
            end else begin
                unlink_order(id);
                r.status = STAT_CANCELLED;
            end
        end else if (ord_live[id]) begin
            r.status = STAT_DUPLICATE;
        end else if (qty == 0) begin
            r.status = STAT_ZERO_QTY;
        end else begin
            ord_live[id] = 1;
            ord_side[id] = sd;
            ord_px[id]   = px;
            ord_left[id] = qty;
            ord_next[id] = NO_LINK;
            lv = (sd ? LEVELS : 0) + px;
            if (!lvl_busy[lv]) begin
                ord_prev[id] = NO_LINK;
                lvl_head[lv] = id;
                lvl_busy[lv] = 1;
            end else begin
                ord_prev[id] = lvl_tail[lv];
                ord_next[lvl_tail[lv]] = id;
            end
            lvl_tail[lv] = id;
            if (sd == SIDE_ASK) begin
                if (top_ask == NO_PRICE || px < top_ask) top_ask = px;
            end else begin
                if (top_bid == NO_PRICE || px > top_bid) top_bid = px;
            end
            r.status = STAT_ADDED;
            // trade heads while the book is crossed
            while (top_bid != NO_PRICE && top_ask != NO_PRICE && top_bid >= top_ask) begin
                b = lvl_head[top_bid];
                a = lvl_head[LEVELS + top_ask];
                t = ord_left[b] < ord_left[a] ? ord_left[b] : ord_left[a];
                filled += t;
                ord_left[b] -= t;
                ord_left[a] -= t;
                if (ord_left[b] == 0) begin
                    unlink_order(b);
                    removed++;
                end
                if (ord_left[a] == 0) begin
                    unlink_order(a);
                    removed++;
                end
            end
        end
        r.filled  = filled[15:0];
        r.removed = removed[12:0];
        r.bid_on  = top_bid != NO_PRICE;
        r.bid_px  = top_bid != NO_PRICE ? top_bid[9:0] : '0;
        r.ask_on  = top_ask != NO_PRICE;
        r.ask_px  = top_ask != NO_PRICE ? top_ask[9:0] : '0;
        return r;
    endfunction

    // send one request; valid stays high for the caller to reuse or lower
    task automatic send_request(logic op, logic [11:0] id, logic sd,
                                logic [9:0] px, logic [15:0] qty);
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_order_id   <= id;
        s_side       <= sd;
        s_price_tick <= px;
        s_quantity   <= qty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_fills.push_back(apply_request(op, id, sd, px, qty));
    endtask

    // random sender gap
    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic add_order(int id, logic sd, int px, int qty);
        send_request(OP_ADD, 12'(id), sd, 10'(px), 16'(qty));
        maybe_gap();
    endtask

    task automatic cancel_order(int id);
        send_request(OP_CANCEL, 12'(id), 1'($urandom_range(0, 1)), 10'($urandom),
                     16'($urandom));
        maybe_gap();
    endtask

    task automatic wait_book_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_fills.size() != 0) @(posedge aclk);
    endtask

    function automatic int pick_live_id();
        int id;
        for (int k = 0; k < 16; k++) begin
            id = $urandom_range(0, SLOTS - 1);
            if (ord_live[id]) return id;
        end
        return $urandom_range(0, SLOTS - 1);
    endfunction

    // extremes, rejections, fifo priority and level sweeps
    task automatic test_directed();
        add_order(0, SIDE_BID, 1023, 16'hFFFF);
        add_order(1, SIDE_ASK, 0, 1);
        add_order(0, SIDE_ASK, 5, 7);
        add_order(2, SIDE_BID, 10, 0);
        cancel_order(4095);
        cancel_order(0);
        add_order(4095, SIDE_ASK, 1023, 16'hFFFF);
        add_order(5, SIDE_BID, 1023, 16'hFFFF);
        add_order(10, SIDE_BID, 100, 3);
        add_order(11, SIDE_BID, 100, 4);
        add_order(12, SIDE_BID, 100, 5);
        add_order(13, SIDE_ASK, 90, 20);
        add_order(14, SIDE_BID, 95, 8);
        add_order(20, SIDE_ASK, 200, 1);
        add_order(21, SIDE_ASK, 201, 1);
        add_order(22, SIDE_ASK, 300, 5);
        add_order(23, SIDE_BID, 1000, 4);
        cancel_order(22);
        cancel_order(22);
        add_order(30, SIDE_BID, 0, 16'h8000);
        add_order(31, SIDE_ASK, 0, 16'h7FFF);
        cancel_order(30);
    endtask

    // mostly well-formed flow around a drifting mid price, some noise
    task automatic test_random_flow(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                mid_px = $urandom_range(100, 900);
            if (pick < 60)
                add_order($urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1)),
                          mid_px + $urandom_range(0, 12) - 6, $urandom_range(1, 300));
            else if (pick < 85)
                cancel_order(pick_live_id());
            else begin
                send_request(1'($urandom_range(0, 1)), 12'($urandom), 1'($urandom),
                             10'($urandom), 16'($urandom));
                maybe_gap();
            end
        end
    endtask

    // sender holds until every result is back
    task automatic test_drain_pause();
        wait_book_drained();
        add_order(pick_live_id(), SIDE_BID, mid_px, 50);
        wait_book_drained();
    endtask

    // compare one result field
    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        book_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fills.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual status %0d",
                         $time, m_status);
            end else begin
                e = pending_fills.pop_front();
                check_field("status", e.status, m_status);
                check_field("filled_quantity", e.filled, m_filled_quantity);
                check_field("orders_removed", e.removed, m_orders_removed);
                check_field("bid_present", e.bid_on, m_bid_present);
                check_field("best_bid_price", e.bid_px, m_best_bid_price);
                check_field("ask_present", e.ask_on, m_ask_present);
                check_field("best_ask_price", e.ask_px, m_best_ask_price);
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet_phase) begin
            m_ready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            m_ready     <= idle_cycles == 1;
        end else if ($urandom_range(0, 4) == 0) begin
            idle_cycles <= $urandom_range(1, 13);
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    int stuck_cycles;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        quiet_phase  = 0;
        mid_px       = 512;
        top_bid      = NO_PRICE;
        top_ask      = NO_PRICE;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_ADD;
        s_order_id   = '0;
        s_side       = SIDE_BID;
        s_price_tick = '0;
        s_quantity   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_flow(600);
        test_drain_pause();
        test_random_flow(650);
        quiet_phase = 1;
        test_random_flow(175);
        wait_book_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
